[rtl/core/lqmp_pkg.sv]
package lqmp_pkg;

    localparam int TIME_WIDTH    = 24;
    localparam int PENALTY_WIDTH = 24;
    localparam int SILENCE_WIDTH = 24;
    localparam int ELAPSED_WIDTH = 16;
    localparam int INTERVAL_WIDTH = 16;
    localparam int CMP_WIDTH     = (TIME_WIDTH > PENALTY_WIDTH) ? TIME_WIDTH : PENALTY_WIDTH;
    localparam int ADDR_WIDTH    = 4;
    localparam int DATA_WIDTH    = 32;

    typedef logic [TIME_WIDTH-1:0]     time_t;
    typedef logic [PENALTY_WIDTH-1:0]  penalty_t;
    typedef logic [INTERVAL_WIDTH-1:0] interval_t;
    typedef logic [1:0]                reg_index_t;

    localparam reg_index_t REG_TIMEOUT       = 2'd0;
    localparam reg_index_t REG_GOOD_INTERVAL = 2'd1;
    localparam reg_index_t REG_BAD_INTERVAL  = 2'd2;
    localparam reg_index_t REG_INIT_PENALTY  = 2'd3;

    localparam logic [SILENCE_WIDTH-1:0] TIMEOUT_RESET       = SILENCE_WIDTH'(10000);
    localparam interval_t                GOOD_INTERVAL_RESET = INTERVAL_WIDTH'(33);
    localparam interval_t                BAD_INTERVAL_RESET  = INTERVAL_WIDTH'(100);
    localparam penalty_t                 INIT_PENALTY_RESET  = PENALTY_WIDTH'(1000);

    localparam penalty_t PENALTY_FLOOR = PENALTY_WIDTH'(1000);
    localparam penalty_t PENALTY_MAX   = {PENALTY_WIDTH{1'b1}};
    localparam time_t    STABLE_PERIOD = TIME_WIDTH'(10000);
    localparam time_t    TIME_MAX      = {TIME_WIDTH{1'b1}};

    function automatic time_t sat_add(input time_t a, input logic [ELAPSED_WIDTH-1:0] b);
        logic [TIME_WIDTH:0] s;
        s = {1'b0, a} + (TIME_WIDTH+1)'(b);
        return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/link_quality_mode_pacer.sv]
// Congestion mode pacer for one connection. Each tick beat on the input
// channel carries the elapsed time, the silence since the last received
// packet and an RTT-good flag; exactly one result beat follows, carrying the
// timeout flag, the mode after the step, the send trigger and the current
// penalty. A tick is taken every cycle unless a waiting result is stalled:
// one pass of compares, saturating adds and shifts feeds the state and result
// registers, and a result register decouples the output, so throughput is one
// beat per cycle and a result appears in the cycle after its tick. Config
// writes apply to the next tick; a written initial penalty loads only at timeout.
module link_quality_mode_pacer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lqmp_pkg::ELAPSED_WIDTH-1:0]  elapsed_ms,
    input  logic [lqmp_pkg::SILENCE_WIDTH-1:0]  since_received_ms,
    input  logic                                rtt_good,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                timed_out,
    output logic                                good_mode,
    output logic                                send_now,
    output logic [lqmp_pkg::PENALTY_WIDTH-1:0]  penalty_ms,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lqmp_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [lqmp_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [lqmp_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                pready
);

    logic [lqmp_pkg::SILENCE_WIDTH-1:0] timeout_reg;
    lqmp_pkg::interval_t                good_interval_reg;
    lqmp_pkg::interval_t                bad_interval_reg;
    lqmp_pkg::penalty_t                 init_penalty_reg;

    logic                 mode_good_reg, mode_good_next;
    lqmp_pkg::time_t      stable_reg, stable_next;
    lqmp_pkg::time_t      switch_reg, switch_next;
    lqmp_pkg::time_t      send_timer_reg, send_timer_next;
    lqmp_pkg::penalty_t   penalty_reg, penalty_next;

    logic                 out_valid_reg;
    logic                 timed_out_reg, timed_out_next;
    logic                 send_now_reg, send_now_next;

    logic                 in_accept;
    logic                 cfg_write;
    lqmp_pkg::reg_index_t cfg_index;
    lqmp_pkg::penalty_t   reset_penalty;
    lqmp_pkg::time_t      stable_add, switch_add, send_add;
    lqmp_pkg::penalty_t   halved;
    lqmp_pkg::time_t      interval;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[lqmp_pkg::ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg       <= lqmp_pkg::TIMEOUT_RESET;
            good_interval_reg <= lqmp_pkg::GOOD_INTERVAL_RESET;
            bad_interval_reg  <= lqmp_pkg::BAD_INTERVAL_RESET;
            init_penalty_reg  <= lqmp_pkg::INIT_PENALTY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lqmp_pkg::REG_TIMEOUT:
                    timeout_reg <= pwdata[lqmp_pkg::SILENCE_WIDTH-1:0];
                lqmp_pkg::REG_GOOD_INTERVAL:
                    good_interval_reg <= pwdata[lqmp_pkg::INTERVAL_WIDTH-1:0];
                lqmp_pkg::REG_BAD_INTERVAL:
                    bad_interval_reg <= pwdata[lqmp_pkg::INTERVAL_WIDTH-1:0];
                lqmp_pkg::REG_INIT_PENALTY:
                    init_penalty_reg <= pwdata[lqmp_pkg::PENALTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            lqmp_pkg::REG_TIMEOUT:
                prdata = lqmp_pkg::DATA_WIDTH'(timeout_reg);
            lqmp_pkg::REG_GOOD_INTERVAL:
                prdata = lqmp_pkg::DATA_WIDTH'(good_interval_reg);
            lqmp_pkg::REG_BAD_INTERVAL:
                prdata = lqmp_pkg::DATA_WIDTH'(bad_interval_reg);
            lqmp_pkg::REG_INIT_PENALTY:
                prdata = lqmp_pkg::DATA_WIDTH'(init_penalty_reg);
            default:
                prdata = '0;
        endcase
    end

    // Hold the tick while a result waits and is not taken.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign reset_penalty = (init_penalty_reg < lqmp_pkg::PENALTY_FLOOR)
                         ? lqmp_pkg::PENALTY_FLOOR : init_penalty_reg;
    assign stable_add = lqmp_pkg::sat_add(stable_reg, elapsed_ms);
    assign switch_add = lqmp_pkg::sat_add(switch_reg, elapsed_ms);
    assign send_add   = lqmp_pkg::sat_add(send_timer_reg, elapsed_ms);
    assign halved     = penalty_reg >> 1;

    always_comb
    begin
        mode_good_next  = mode_good_reg;
        stable_next     = stable_reg;
        switch_next     = switch_reg;
        send_timer_next = send_timer_reg;
        penalty_next    = penalty_reg;
        timed_out_next  = 1'b0;
        send_now_next   = 1'b0;
        interval        = '0;

        if (since_received_ms >= timeout_reg)
        begin
            mode_good_next  = 1'b0;
            stable_next     = '0;
            switch_next     = '0;
            send_timer_next = '0;
            penalty_next    = reset_penalty;
            timed_out_next  = 1'b1;
        end
        else
        begin
            stable_next = stable_add;
            switch_next = switch_add;

            if (mode_good_reg && !rtt_good)
            begin
                mode_good_next = 1'b0;
                if (switch_add <= lqmp_pkg::STABLE_PERIOD)
                begin
                    penalty_next = penalty_reg[lqmp_pkg::PENALTY_WIDTH-1]
                                 ? lqmp_pkg::PENALTY_MAX : (penalty_reg << 1);
                end
                switch_next = '0;
            end
            else if (mode_good_reg)
            begin
                if (stable_add >= lqmp_pkg::STABLE_PERIOD)
                begin
                    stable_next  = '0;
                    penalty_next = (halved < lqmp_pkg::PENALTY_FLOOR)
                                 ? lqmp_pkg::PENALTY_FLOOR : halved;
                end
            end
            else if (rtt_good)
            begin
                if (lqmp_pkg::CMP_WIDTH'(switch_add) >= lqmp_pkg::CMP_WIDTH'(penalty_reg))
                begin
                    stable_next    = '0;
                    switch_next    = '0;
                    mode_good_next = 1'b1;
                end
            end
            else
            begin
                switch_next = '0;
            end

            interval = mode_good_next ? lqmp_pkg::TIME_WIDTH'(good_interval_reg)
                                      : lqmp_pkg::TIME_WIDTH'(bad_interval_reg);
            if (send_add >= interval)
            begin
                send_timer_next = '0;
                send_now_next   = 1'b1;
            end
            else
            begin
                send_timer_next = send_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_good_reg  <= 1'b0;
            stable_reg     <= '0;
            switch_reg     <= '0;
            send_timer_reg <= '0;
            penalty_reg    <= lqmp_pkg::INIT_PENALTY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                mode_good_reg  <= mode_good_next;
                stable_reg     <= stable_next;
                switch_reg     <= switch_next;
                send_timer_reg <= send_timer_next;
                penalty_reg    <= penalty_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            timed_out_reg <= timed_out_next;
            send_now_reg  <= send_now_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign timed_out  = timed_out_reg;
    assign good_mode  = mode_good_reg;
    assign send_now   = send_now_reg;
    assign penalty_ms = penalty_reg;

`ifndef NO_ASSERTIONS
    a_timeout_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && timed_out_reg |-> !mode_good_reg && !send_now_reg)
        else $error("timeout beat reports good mode or send");

    a_penalty_floor: assert property (@(posedge clk) disable iff (!rst_n)
        penalty_reg >= lqmp_pkg::PENALTY_FLOOR)
        else $error("penalty below floor");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    a_mode_change_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mode_good_reg) |-> $past(in_accept))
        else $error("mode changed without a tick");
`endif

endmodule
